FILE: rtl/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// Vector operation and normalize package
// Shared types and constants for the vector combine and unit-scale pipeline.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  // Width of one vector component (signed fixed point).
  localparam int WordBits = 32;
  // Magnitudes are aligned below 2^MagBits before squaring.
  localparam int MagBits  = 31;
  localparam int SqBits   = 2 * MagBits;
  localparam int SumBits  = SqBits + 2;

  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_ADD   = 2'd1,
    OP_SUB   = 2'd2,
    OP_CROSS = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic                       normalize;
    logic signed [WordBits-1:0] a_x;
    logic signed [WordBits-1:0] a_y;
    logic signed [WordBits-1:0] a_z;
    logic signed [WordBits-1:0] b_x;
    logic signed [WordBits-1:0] b_y;
    logic signed [WordBits-1:0] b_z;
  } vnorm_in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] r_x;
    logic signed [WordBits-1:0] r_y;
    logic signed [WordBits-1:0] r_z;
    logic                       saturated;
  } vnorm_out_t;

  // Control and pass-along data that travels with an item through the cells.
  typedef struct packed {
    logic                           valid;
    logic                           norm;
    logic                           zero;
    logic                           sat;
    logic [2:0]                     neg;
    logic [2:0][WordBits-1:0]       r;
  } vnorm_side_t;

endpackage

FILE: rtl/vnorm_cell.sv
// ----------------------------------------------------------------------------
// Unit-scale quotient cell
// Decides one quotient bit for all three components and hands the partial
// square, partial product and quotient to the next cell.
// ----------------------------------------------------------------------------
module vnorm_cell #(
  parameter int FracBits = 16,
  parameter int BitIdx   = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  vnorm_pkg::vnorm_side_t                side_i,
  input  logic [vnorm_pkg::SumBits-1:0]         s_i,
  input  logic [2:0][2*FracBits+vnorm_pkg::SumBits+1:0] rhs_i,
  input  logic [2:0][2*FracBits+vnorm_pkg::SumBits+1:0] p_i,
  input  logic [2:0][2*FracBits+vnorm_pkg::SumBits+1:0] qs_i,
  input  logic [2:0][FracBits:0]                q_i,
  output vnorm_pkg::vnorm_side_t                side_o,
  output logic [vnorm_pkg::SumBits-1:0]         s_o,
  output logic [2:0][2*FracBits+vnorm_pkg::SumBits+1:0] rhs_o,
  output logic [2:0][2*FracBits+vnorm_pkg::SumBits+1:0] p_o,
  output logic [2:0][2*FracBits+vnorm_pkg::SumBits+1:0] qs_o,
  output logic [2:0][FracBits:0]                q_o
);
  import vnorm_pkg::*;

  localparam int RW = 2 * FracBits + SumBits + 2;

  vnorm_side_t            side_q;
  logic [SumBits-1:0]     s_q;
  logic [2:0][RW-1:0]     rhs_q, p_q, qs_q, p_d, qs_d;
  logic [2:0][FracBits:0] q_q, q_d;
  logic [RW-1:0]          s_ext;

  // Trial (q + 2^b)^2 * S = P + (q*S << (b+1)) + (S << 2b); keep the bit if it fits.
  always_comb begin
    logic [RW-1:0] tp;
    s_ext = RW'(s_i);
    for (int i = 0; i < 3; i++) begin
      tp = p_i[i] + (qs_i[i] << (BitIdx + 1)) + (s_ext << (2 * BitIdx));
      if (tp <= rhs_i[i]) begin
        p_d[i]  = tp;
        qs_d[i] = qs_i[i] + (s_ext << BitIdx);
        q_d[i]  = q_i[i] | ((FracBits+1)'(1) << BitIdx);
      end else begin
        p_d[i]  = p_i[i];
        qs_d[i] = qs_i[i];
        q_d[i]  = q_i[i];
      end
    end
  end

  // Control part of the handoff.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  // Data part of the handoff.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= s_i;
      rhs_q <= rhs_i;
      p_q   <= p_d;
      qs_q  <= qs_d;
      q_q   <= q_d;
    end
  end

  assign side_o = side_q;
  assign s_o    = s_q;
  assign rhs_o  = rhs_q;
  assign p_o    = p_q;
  assign qs_o   = qs_q;
  assign q_o    = q_q;

endmodule

FILE: rtl/vector_op_normalize_top.sv
// ----------------------------------------------------------------------------
// Vector operation and normalize
// Combines two signed fixed-point 3-vectors and optionally scales to unit length.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns one result per item, in order. Each item passes through six front
// stages for the vector operation, clamping, magnitude alignment, squaring
// and summing, then the chain of quotient cells, one cell per fraction bit
// plus one, and the output register. A stall on the output holds the whole
// pipeline.
module vector_op_normalize_top #(
  parameter int FracBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  vnorm_pkg::vnorm_in_t   in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output vnorm_pkg::vnorm_out_t  out_o
);
  import vnorm_pkg::*;

  localparam int RW    = 2 * FracBits + SumBits + 2;
  localparam int Cells = FracBits + 1;
  localparam int WB    = WordBits;

  logic en;
  logic out_valid_q;
  vnorm_out_t out_q;

  // Everything advances unless a finished item is held at the output.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: capture the item.
  logic      v1_q;
  vnorm_in_t in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_i;
    end
  end

  // Stage 2: products for the cross product, sums and differences.
  logic                       v2_q;
  logic [1:0]                 op2_q;
  logic                       norm2_q;
  logic [2:0][WB-1:0]         a2_q;
  logic [2:0][WB:0]           add2_q, sub2_q;
  logic signed [2*WB-1:0]     pr2_q [6];
  logic signed [WB-1:0]       av [3], bv [3];
  always_comb begin
    av[0] = in_q.a_x; av[1] = in_q.a_y; av[2] = in_q.a_z;
    bv[0] = in_q.b_x; bv[1] = in_q.b_y; bv[2] = in_q.b_z;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q   <= in_q.operation;
      norm2_q <= in_q.normalize;
      for (int i = 0; i < 3; i++) begin
        a2_q[i]   <= av[i];
        add2_q[i] <= {av[i][WB-1], av[i]} + {bv[i][WB-1], bv[i]};
        sub2_q[i] <= {av[i][WB-1], av[i]} - {bv[i][WB-1], bv[i]};
      end
      pr2_q[0] <= av[1] * bv[2];
      pr2_q[1] <= av[2] * bv[1];
      pr2_q[2] <= av[2] * bv[0];
      pr2_q[3] <= av[0] * bv[2];
      pr2_q[4] <= av[0] * bv[1];
      pr2_q[5] <= av[1] * bv[0];
    end
  end

  // Stage 3: select the operation and clamp each component.
  logic               v3_q, norm3_q, sat3_q;
  logic [2:0][WB-1:0] r3_q;
  logic [2:0][WB-1:0] r3_d;
  logic               sat3_d;
  always_comb begin
    logic signed [2*WB:0] diff, shd;
    logic [WB:0]          w;
    sat3_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r3_d[i] = a2_q[i];
      case (op2_q) inside
        OP_ADD, OP_SUB: begin
          w = (op2_q == OP_ADD) ? add2_q[i] : sub2_q[i];
          if (w[WB] != w[WB-1]) begin
            sat3_d  = 1'b1;
            r3_d[i] = {w[WB], {(WB-1){~w[WB]}}};
          end else begin
            r3_d[i] = w[WB-1:0];
          end
        end
        OP_CROSS: begin
          diff = (2*WB+1)'(pr2_q[2*i]) - (2*WB+1)'(pr2_q[2*i+1]);
          shd  = diff >>> FracBits;
          if (shd[2*WB:WB-1] != {(WB+2){shd[2*WB]}}) begin
            sat3_d  = 1'b1;
            r3_d[i] = {shd[2*WB], {(WB-1){~shd[2*WB]}}};
          end else begin
            r3_d[i] = shd[WB-1:0];
          end
        end
        default: r3_d[i] = a2_q[i];
      endcase
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      norm3_q <= norm2_q;
      sat3_q  <= sat3_d;
      r3_q    <= r3_d;
    end
  end

  // Stage 4: magnitudes aligned below 2^MagBits by a common shift.
  vnorm_side_t            side4_q;
  logic [2:0][MagBits-1:0] m4_q;
  logic [2:0][MagBits-1:0] m4_d;
  logic [2:0]             neg4;
  logic                   zero4;
  always_comb begin
    logic [2:0][WB-1:0] m;
    logic [WB-1:0]      mor;
    logic [$clog2(WB)-1:0] hi, sh;
    mor = '0;
    for (int i = 0; i < 3; i++) begin
      neg4[i] = r3_q[i][WB-1];
      m[i]    = neg4[i] ? (WB'(0) - r3_q[i]) : r3_q[i];
      mor     = mor | m[i];
    end
    hi = '0;
    for (int k = 0; k < WB; k++) begin
      if (mor[k]) hi = ($clog2(WB))'(k);
    end
    sh = (hi > ($clog2(WB))'(MagBits - 1)) ? hi - ($clog2(WB))'(MagBits - 1) : '0;
    for (int i = 0; i < 3; i++) begin
      m4_d[i] = MagBits'(m[i] >> sh);
    end
    zero4 = (mor == '0);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side4_q <= '0;
    end else if (en) begin
      side4_q.valid <= v3_q;
      side4_q.norm  <= norm3_q;
      side4_q.zero  <= zero4;
      side4_q.sat   <= sat3_q;
      side4_q.neg   <= neg4;
      side4_q.r     <= r3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_q <= m4_d;
    end
  end

  // Stage 5: squares of the aligned magnitudes.
  vnorm_side_t            side5_q;
  logic [2:0][SqBits-1:0] sq5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side5_q <= '0;
    end else if (en) begin
      side5_q <= side4_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= SqBits'(m4_q[i]) * SqBits'(m4_q[i]);
      end
    end
  end

  // Stage 6: sum of squares and the scaled right-hand sides.
  vnorm_side_t          side6_q;
  logic [SumBits-1:0]   s6_q;
  logic [2:0][RW-1:0]   rhs6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side6_q <= '0;
    end else if (en) begin
      side6_q <= side5_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q <= SumBits'(sq5_q[0]) + SumBits'(sq5_q[1]) + SumBits'(sq5_q[2]);
      for (int i = 0; i < 3; i++) begin
        rhs6_q[i] <= RW'(sq5_q[i]) << (2 * FracBits);
      end
    end
  end

  // Chain of quotient cells, most significant quotient bit first.
  vnorm_side_t            side_c [Cells+1];
  logic [SumBits-1:0]     s_c    [Cells+1];
  logic [2:0][RW-1:0]     rhs_c  [Cells+1];
  logic [2:0][RW-1:0]     p_c    [Cells+1];
  logic [2:0][RW-1:0]     qs_c   [Cells+1];
  logic [2:0][FracBits:0] q_c    [Cells+1];

  assign side_c[0] = side6_q;
  assign s_c[0]    = s6_q;
  assign rhs_c[0]  = rhs6_q;
  assign p_c[0]    = '0;
  assign qs_c[0]   = '0;
  assign q_c[0]    = '0;

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    vnorm_cell #(
      .FracBits(FracBits),
      .BitIdx  (FracBits - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_c[k]),
      .s_i    (s_c[k]),
      .rhs_i  (rhs_c[k]),
      .p_i    (p_c[k]),
      .qs_i   (qs_c[k]),
      .q_i    (q_c[k]),
      .side_o (side_c[k+1]),
      .s_o    (s_c[k+1]),
      .rhs_o  (rhs_c[k+1]),
      .p_o    (p_c[k+1]),
      .qs_o   (qs_c[k+1]),
      .q_o    (q_c[k+1])
    );
  end

  // Output register: signed quotient or the clamped vector.
  vnorm_side_t        side_l;
  logic [2:0][WB-1:0] res;
  assign side_l = side_c[Cells];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_l.norm && !side_l.zero) begin
        res[i] = side_l.neg[i] ? (WB'(0) - WB'(q_c[Cells][i])) : WB'(q_c[Cells][i]);
      end else begin
        res[i] = side_l.r[i];
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_l.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.r_x       <= res[0];
      out_q.r_y       <= res[1];
      out_q.r_z       <= res[2];
      out_q.saturated <= side_l.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The input is held back only while a finished item waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a held output item");

  // Passing the first vector through can never clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v2_q && op2_q == OP_PASS) |=> !sat3_q)
    else $error("pass operation raised the saturated flag");

  // A normalized nonzero result has an x component no larger than one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && side_l.valid && side_l.norm && !side_l.zero) |->
      (q_c[Cells][0] <= (FracBits+1)'(1) << FracBits))
    else $error("unit-scale quotient exceeds one");

endmodule
